FILE: rtl/sem_pkg.sv
package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 20;
    localparam int RAD_W   = 16;
    localparam int REM_W   = 11;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_SIZE     = 3;

    localparam logic [SQ_W:0]    MAG_SAT_LIMIT = (SQ_W+1)'(65025);
    localparam logic [PIX_W-1:0] MAG_MAX       = PIX_W'(255);

    localparam int SQRT_STAGES = 4;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             sat;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [PIX_W-1:0] root;
    } t_sqrt;

    // saturate a size into [3, hi] and return size - 1
    function automatic int clamp_last(int v, int hi);
        int s;
        begin
            s = v;
            if (v < MIN_SIZE) begin
                s = MIN_SIZE;
            end else if (v > hi) begin
                s = hi;
            end
            return s - 1;
        end
    endfunction

    // 1-2-1 weighted sum of three pixels
    function automatic logic [PIX_W+1:0] col_sum(logic [PIX_W-1:0] a,
                                                 logic [PIX_W-1:0] b,
                                                 logic [PIX_W-1:0] c);
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // one restoring square root digit
    function automatic t_sqrt sqrt_step(t_sqrt s);
        t_sqrt            r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        begin
            r      = s;
            rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
            trial  = {1'b0, s.root, 2'b01};
            if (rem_sh >= trial) begin
                r.rem  = rem_sh - trial;
                r.root = {s.root[PIX_W-2:0], 1'b1};
            end else begin
                r.rem  = rem_sh;
                r.root = {s.root[PIX_W-2:0], 1'b0};
            end
            r.rad = {s.rad[RAD_W-3:0], 2'b00};
            return r;
        end
    endfunction

endpackage

FILE: rtl/sem_ram.sv
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sem_line_window.sv
module sem_line_window #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_accept,
    input  logic [sem_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_frame_start,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_wlast,
    input  logic [$clog2(MAX_HEIGHT)-1:0]  i_hlast,
    output sem_pkg::t_grad                 o_grad
);

    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]    r_col, n_col, col;
    logic [RW-1:0]    r_row, n_row, row;
    logic             col_wrap, row_wrap;

    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_col;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s1_emit;
    logic             r_s1_last;

    logic [PIX_W-1:0] upper_rd, middle_rd;
    logic [PIX_W-1:0] top_eff, mid_eff;
    logic             wr_en;

    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_top, r_fwd_mid;

    logic [PIX_W-1:0] r_win [6];

    logic [PIX_W+1:0]         sum_l, sum_r, sum_t, sum_b;
    logic signed [GRAD_W-1:0] gx, gy;
    t_grad                    r_grad;

    // position of the incoming pixel
    always_comb begin
        col      = i_frame_start ? '0 : r_col;
        row      = i_frame_start ? '0 : r_row;
        col_wrap = (col >= i_wlast);
        row_wrap = (row >= i_hlast);
        n_col    = col_wrap ? '0 : col + CW'(1);
        if (col_wrap) begin
            n_row = row_wrap ? '0 : row + RW'(1);
        end else begin
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_accept) begin
            r_s1_col   <= col;
            r_s1_pixel <= i_pixel;
            r_s1_emit  <= (row >= RW'(2)) && (col >= CW'(2));
            r_s1_last  <= (row == i_hlast) && (col == i_wlast);
        end
    end

    // read-modify-write of both line stores
    assign wr_en = i_en && r_s1_valid;

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_col),
        .i_wdata (mid_eff),
        .i_re    (i_accept),
        .i_raddr (col),
        .o_rdata (upper_rd)
    );

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pixel),
        .i_re    (i_accept),
        .i_raddr (col),
        .o_rdata (middle_rd)
    );

    // bypass when the read hits the entry being written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_en) begin
            r_fwd <= i_accept && wr_en && (col == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_top <= mid_eff;
            r_fwd_mid <= r_s1_pixel;
        end
    end

    assign top_eff = r_fwd ? r_fwd_top : upper_rd;
    assign mid_eff = r_fwd ? r_fwd_mid : middle_rd;

    // sobel kernels
    always_comb begin
        sum_l = col_sum(r_win[0], r_win[1], r_win[2]);
        sum_r = col_sum(top_eff, mid_eff, r_s1_pixel);
        sum_t = col_sum(r_win[0], r_win[3], top_eff);
        sum_b = col_sum(r_win[2], r_win[5], r_s1_pixel);
        gx    = $signed({1'b0, sum_l} - {1'b0, sum_r});
        gy    = $signed({1'b0, sum_t} - {1'b0, sum_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_grad.valid <= 1'b0;
        end else if (i_en) begin
            r_grad.valid <= r_s1_valid && r_s1_emit;
            r_grad.last  <= r_s1_last;
            r_grad.gx    <= gx;
            r_grad.gy    <= gy;
            if (r_s1_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top_eff;
                r_win[4] <= mid_eff;
                r_win[5] <= r_s1_pixel;
            end
        end
    end

    assign o_grad = r_grad;

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("line store bypass armed without an item in flight");

    a_frame_start_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_accept && i_frame_start) |=> (r_s1_valid && r_s1_col == '0))
        else $error("frame start did not restart the column");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_col) && $stable(r_row) && $stable(r_s1_valid)))
        else $error("window state moved while held");

endmodule

FILE: rtl/sem_magnitude.sv
module sem_magnitude (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  sem_pkg::t_grad            i_grad,
    output logic                      o_valid,
    output logic [sem_pkg::PIX_W-1:0] o_magnitude,
    output logic                      o_last
);

    import sem_pkg::*;

    logic signed [2*GRAD_W-1:0] px, py;
    logic                       r_a_valid, r_a_last;
    logic [SQ_W-1:0]            r_sqx, r_sqy;
    logic [SQ_W:0]              sum;

    t_sqrt r_sq [SQRT_STAGES+1];

    logic             r_out_valid;
    logic             r_out_last;
    logic [PIX_W-1:0] r_out_mag;

    assign px  = i_grad.gx * i_grad.gx;
    assign py  = i_grad.gy * i_grad.gy;
    assign sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_grad.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_last <= i_grad.last;
            r_sqx    <= px[SQ_W-1:0];
            r_sqy    <= py[SQ_W-1:0];
        end
    end

    // saturate, then two root digits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SQRT_STAGES; i++) begin
                r_sq[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_sq[0].valid <= r_a_valid;
            r_sq[0].last  <= r_a_last;
            r_sq[0].sat   <= (sum >= MAG_SAT_LIMIT);
            r_sq[0].rad   <= (sum >= MAG_SAT_LIMIT) ? '0 : sum[RAD_W-1:0];
            r_sq[0].rem   <= '0;
            r_sq[0].root  <= '0;
            for (int i = 1; i <= SQRT_STAGES; i++) begin
                r_sq[i] <= sqrt_step(sqrt_step(r_sq[i-1]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_sq[SQRT_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_last <= r_sq[SQRT_STAGES].last;
            r_out_mag  <= r_sq[SQRT_STAGES].sat ? MAG_MAX : r_sq[SQRT_STAGES].root;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_last      = r_out_last;

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_sq[SQRT_STAGES].valid) |=> r_out_valid)
        else $error("finished root did not reach the output");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !r_sq[SQRT_STAGES].valid) |=> !r_out_valid)
        else $error("output beat without a root behind it");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq[SQRT_STAGES].valid && !r_sq[SQRT_STAGES].sat)
            |-> (r_sq[SQRT_STAGES].rem <= {2'b00, r_sq[SQRT_STAGES].root, 1'b0}))
        else $error("root remainder out of range");

endmodule

FILE: rtl/sobel_edge_magnitude_unit.sv
// channel  | valid        | flow          | payload
// ---------+--------------+---------------+------------------------------
// pixel in | i_in_valid   | o_in_stall    | i_pixel, i_frame_start
// edge out | o_out_valid  | i_out_stall   | o_magnitude, o_frame_end
// config   | i_cfg_valid  | o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one pixel per cycle while the output does not stall
// the line stores are read at accept and written back from the stage-1 registers,
// with a bypass when a frame start lands on the column just written
// i_rst_n is synchronous and clears counters, window and valid bits
// a stalled output beat holds the whole pipeline and stalls the input

module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [sem_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_frame_start,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [sem_pkg::PIX_W-1:0] o_magnitude,
    output logic                      o_frame_end,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0] i_cfg_data
);

    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_wlast;
    logic [RW-1:0] r_hlast;
    logic          en;
    logic          accept;
    t_grad         grad;
    logic          out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= CW'(clamp_last(WIDTH_RESET, MAX_WIDTH));
            r_hlast <= RW'(clamp_last(HEIGHT_RESET, MAX_HEIGHT));
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_wlast <= CW'(clamp_last(int'(i_cfg_data), MAX_WIDTH));
                end
                CFG_IMAGE_HEIGHT: begin
                    r_hlast <= RW'(clamp_last(int'(i_cfg_data), MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    assign en         = !(out_valid && i_out_stall);
    assign accept     = i_in_valid && en;
    assign o_in_stall = !en;

    sem_line_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_wlast       (r_wlast),
        .i_hlast       (r_hlast),
        .o_grad        (grad)
    );

    sem_magnitude u_magnitude (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_grad      (grad),
        .o_valid     (out_valid),
        .o_magnitude (o_magnitude),
        .o_last      (o_frame_end)
    );

    assign o_out_valid = out_valid;

endmodule
